>>> rtl/core/tsps_pkg.sv
// ----------------------------------------------------------------------------
// tsps_pkg: shared types and constants of the train speed profile step
// Field widths, fixed-point constants, action and register codes.
// ----------------------------------------------------------------------------
package tsps_pkg;

  localparam int unsigned LEN_W   = 32;  // segment length, position: 1/256 m
  localparam int unsigned SPEED_W = 16;  // speeds and rates: 1/256 m/s
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // 2 m stopping margin and 0.1 m/s hysteresis in fixed point
  localparam int unsigned MARGIN_UNITS = 512;
  localparam int unsigned HYST_UNITS   = 26;

  localparam logic [SPEED_W-1:0] ACCEL_RESET = SPEED_W'(256);
  localparam logic [SPEED_W-1:0] DECEL_RESET = SPEED_W'(256);

  // serial units: multiplier (v-T)*(v+T), divider by 2*decel
  localparam int unsigned MUL_A_W   = SPEED_W;
  localparam int unsigned MUL_B_W   = SPEED_W + 1;
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_A_W);
  localparam int unsigned DIV_N_W   = LEN_W;
  localparam int unsigned DIV_D_W   = SPEED_W + 1;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W);

  typedef logic [1:0] action_t;
  localparam action_t ACT_BRAKE    = 2'd0;
  localparam action_t ACT_ACCEL    = 2'd1;
  localparam action_t ACT_MAINTAIN = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_ACCEL = 1'd0;
  localparam cfg_idx_t REG_DECEL = 1'd1;

  // handshake between the sequencer and a serial unit
  typedef struct packed {
    logic start;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

>>> rtl/core/tsps_mul.sv
// ----------------------------------------------------------------------------
// tsps_mul: bit-serial shift-add multiplier
// Retires one bit of the multiplier operand a per cycle; done pulses once
// the product register holds a*b.
// ----------------------------------------------------------------------------
module tsps_mul
  import tsps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  unit_ctl_t          ctl,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output unit_sts_t          sts,
  output logic [MUL_P_W-1:0] prod
);

  logic [MUL_B_W-1:0]   b_hold;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [MUL_B_W:0]     partial;

  // add the multiplicand into the upper half when the retiring bit is set
  assign partial = {1'b0, prod[MUL_P_W-1:MUL_A_W]}
                 + (prod[0] ? {1'b0, b_hold} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_A_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      prod   <= {{MUL_B_W{1'b0}}, a};
      b_hold <= b;
    end else if (busy) begin
      prod <= {partial, prod[MUL_A_W-1:1]};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

>>> rtl/core/tsps_div.sv
// ----------------------------------------------------------------------------
// tsps_div: radix-2 restoring divider
// Produces one quotient bit per cycle, most significant first; done pulses
// once quo holds floor(n/d).
// ----------------------------------------------------------------------------
module tsps_div
  import tsps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  unit_ctl_t          ctl,
  input  logic [DIV_N_W-1:0] n,
  input  logic [DIV_D_W-1:0] d,
  output unit_sts_t          sts,
  output logic [DIV_N_W-1:0] quo
);

  logic [DIV_D_W-1:0]   d_hold;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W:0]     diff;
  logic                 fits;

  assign trial = {rem, quo[DIV_N_W-1]};
  assign diff  = trial - {1'b0, d_hold};
  assign fits  = trial >= {1'b0, d_hold};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo    <= n;
      rem    <= '0;
      d_hold <= d;
    end else if (busy) begin
      rem <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      quo <= {quo[DIV_N_W-2:0], fits};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

>>> rtl/core/train_speed_profile_step.sv
// ----------------------------------------------------------------------------
// train_speed_profile_step: one tick of a trapezoidal speed profile
// Brakes, accelerates or holds the segment limit, then advances the position
// on the segment by the mean speed; latches arrival at the last segment end.
//
//   channel   direction  handshake              payload
//   item      in         item_valid/item_stall  segment_length, speed_limit,
//                                               next_limit, last_segment
//   result    out        result_valid/          speed_now, position_now,
//                        result_stall           action, segment_done, arrived
//   config    in         cfg_we                 cfg_index, cfg_data
//
// A tick starts at the accept with the serial multiplier for v^2 - T^2,
// whose done pulse hands the product over and starts the restoring divider
// for the braking distance; the divider's done pulse leaves the calculation
// for the commit state, which decides and loads the result register. Once
// arrived, an accepted tick goes straight to the commit state.
// item_stall is high from the accept until the result is committed; a
// result stalled downstream holds the commit, but a waiting result does not
// block the next transaction. Synchronous reset clears speed, position and
// the arrived flag and loads both rates with 1 m/s per tick.
// ----------------------------------------------------------------------------
module train_speed_profile_step
  import tsps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input transactions
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [LEN_W-1:0]   segment_length,
  input  logic [SPEED_W-1:0] speed_limit,
  input  logic [SPEED_W-1:0] next_limit,
  input  logic               last_segment,
  // result transactions
  output logic               result_valid,
  input  logic               result_stall,
  output logic [SPEED_W-1:0] speed_now,
  output logic [LEN_W-1:0]   position_now,
  output action_t            action,
  output logic               segment_done,
  output logic               arrived,
  // configuration
  input  logic               cfg_we,
  input  cfg_idx_t           cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // configuration and profile state
  logic [SPEED_W-1:0] accel_rate;
  logic [SPEED_W-1:0] decel_rate;
  logic [SPEED_W-1:0] speed;
  logic [LEN_W-1:0]   position;
  logic               done_flag;

  // latched transaction
  logic [LEN_W-1:0]   seg_len;
  logic [SPEED_W-1:0] lim;
  logic [SPEED_W-1:0] tgt;
  logic               last;

  logic item_acc;
  logic out_free;
  logic commit;

  // ---- target end speed and multiplier operands, from the ports and the current speed
  logic [SPEED_W-1:0] tgt_in;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;

  assign tgt_in = last_segment ? '0 :
                  (next_limit < speed_limit ? next_limit : speed_limit);
  // (v-T)(v+T) = v^2 - T^2; zero when not above the target
  assign mul_a  = (speed > tgt_in) ? speed - tgt_in : '0;
  assign mul_b  = {1'b0, speed} + {1'b0, tgt_in};

  assign item_stall = (state != ST_IDLE);
  assign item_acc   = item_valid && !item_stall;

  // ---- serial units
  unit_ctl_t          mul_ctl;
  unit_sts_t          mul_sts;
  logic [MUL_P_W-1:0] mul_prod;
  unit_ctl_t          div_ctl;
  unit_sts_t          div_sts;
  logic [DIV_N_W-1:0] brake_dist;
  logic [DIV_D_W-1:0] div_d;

  // divide by 2*decel, with a zero rate taken as 1
  assign div_d = {((decel_rate == '0) ? SPEED_W'(1) : decel_rate), 1'b0};

  assign mul_ctl.start = item_acc && !done_flag;
  assign div_ctl.start = mul_sts.done;

  tsps_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mul_ctl),
    .a    (mul_a),
    .b    (mul_b),
    .sts  (mul_sts),
    .prod (mul_prod)
  );

  tsps_div u_div (
    .clk (clk),
    .rst (rst),
    .ctl (div_ctl),
    .n   (mul_prod[DIV_N_W-1:0]),
    .d   (div_d),
    .sts (div_sts),
    .quo (brake_dist)
  );

  // ---- decision
  logic               near_end;
  logic               above_tgt;
  logic               do_brake;
  logic               do_accel;
  logic [SPEED_W-1:0] brake_v;
  logic [SPEED_W:0]   accel_sum;
  logic [SPEED_W-1:0] accel_v;
  logic [SPEED_W-1:0] new_v;
  action_t            new_act;
  logic [SPEED_W:0]   speed_sum;
  logic [LEN_W:0]     pos_sum;
  logic [LEN_W-1:0]   pos_clamp;
  logic               reached;

  always_comb begin
    // brake when within braking distance plus margin of the end and above the target
    near_end  = {2'b0, seg_len} <=
                ({2'b0, position} + {2'b0, brake_dist} + (LEN_W+2)'(MARGIN_UNITS));
    above_tgt = {1'b0, speed} >= ({1'b0, tgt} + (SPEED_W+1)'(HYST_UNITS));
    do_brake  = near_end && above_tgt;
    do_accel  = ({1'b0, speed} + (SPEED_W+1)'(HYST_UNITS)) <= {1'b0, lim};

    brake_v = (speed > decel_rate) ? speed - decel_rate : '0;
    if (brake_v < tgt) begin
      brake_v = tgt;
    end
    accel_sum = {1'b0, speed} + {1'b0, accel_rate};
    accel_v   = (accel_sum > {1'b0, lim}) ? lim : accel_sum[SPEED_W-1:0];

    if (do_brake) begin
      new_v   = brake_v;
      new_act = ACT_BRAKE;
    end else if (do_accel) begin
      new_v   = accel_v;
      new_act = ACT_ACCEL;
    end else begin
      new_v   = lim;
      new_act = ACT_MAINTAIN;
    end

    // advance by the mean of old and new speed, clamped to the segment end
    speed_sum = {1'b0, speed} + {1'b0, new_v};
    pos_sum   = {1'b0, position} + {{(LEN_W-SPEED_W+1){1'b0}}, speed_sum[SPEED_W:1]};
    reached   = pos_sum >= {1'b0, seg_len};
    pos_clamp = (pos_sum > {1'b0, seg_len}) ? seg_len : pos_sum[LEN_W-1:0];
  end

  // ---- sequencer
  assign out_free = !result_valid || !result_stall;
  assign commit   = (state == ST_FIN) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_acc) begin
          state_next = done_flag ? ST_FIN : ST_CALC;
        end
      end
      ST_CALC: begin
        if (div_sts.done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // latch the transaction payload
  always_ff @(posedge clk) begin
    if (item_acc) begin
      seg_len <= segment_length;
      lim     <= speed_limit;
      tgt     <= tgt_in;
      last    <= last_segment;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_rate <= ACCEL_RESET;
      decel_rate <= DECEL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACCEL: accel_rate <= cfg_data;
        REG_DECEL: decel_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  // commit profile state; after arrival everything holds
  always_ff @(posedge clk) begin
    if (rst) begin
      speed     <= '0;
      position  <= '0;
      done_flag <= 1'b0;
    end else if (commit && !done_flag) begin
      if (reached && last) begin
        speed     <= '0;
        position  <= pos_clamp;
        done_flag <= 1'b1;
      end else if (reached) begin
        speed    <= new_v;
        position <= '0;
      end else begin
        speed    <= new_v;
        position <= pos_clamp;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (done_flag) begin
        // arrived: answer the held state
        speed_now    <= speed;
        position_now <= position;
        action       <= ACT_BRAKE;
        segment_done <= 1'b0;
        arrived      <= 1'b1;
      end else begin
        speed_now    <= (reached && last) ? '0 : new_v;
        position_now <= (reached && !last) ? '0 : pos_clamp;
        action       <= new_act;
        segment_done <= reached;
        arrived      <= reached && last;
      end
    end
  end

endmodule
